### design/fnc_pkg.sv
// Shared types and constants for the fingerprint nearest-cell block.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package fnc_pkg;

    localparam int SENSOR_COUNT = 4;
    localparam int SENSOR_W     = 16;
    localparam int WORD_W       = SENSOR_COUNT * SENSOR_W;
    localparam int CFG_W        = 5;
    localparam int CFG_IDX_W    = 2;
    localparam int SQ_W         = 2 * SENSOR_W;
    localparam int DIST_W       = SQ_W + 2;
    localparam int DIST_STAGES  = 4;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_LOCATE = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BOUNDS = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LINES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd1;
    localparam logic [CFG_W-1:0]     CFG_RESET   = 5'd16;

    typedef struct packed {
        logic [1:0]         operation;
        logic [3:0]         line;
        logic [3:0]         column;
        logic signed [15:0] sensor_a;
        logic signed [15:0] sensor_b;
        logic signed [15:0] sensor_c;
        logic signed [15:0] sensor_d;
    } t_cmd;

    typedef struct packed {
        logic [1:0]         status;
        logic [3:0]         best_line;
        logic [3:0]         best_column;
        logic signed [15:0] value_a;
        logic signed [15:0] value_b;
        logic signed [15:0] value_c;
        logic signed [15:0] value_d;
    } t_result;

    typedef struct packed {
        logic [3:0] line;
        logic [3:0] column;
    } t_cell_pos;

    typedef struct packed {
        logic wr_en;
        logic wr_cell;
        logic wr_valid;
        logic rd_en;
    } t_mem_req;

endpackage

`default_nettype wire

### design/fnc_store.sv
// Cell memory: one data array of sensor words and one array of valid marks.
// Single port, synchronous read with registered data; uses fnc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fnc_store #(
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire                          i_clk,
    input  wire fnc_pkg::t_mem_req       i_req,
    input  wire [AW-1:0]                 i_addr,
    input  wire [fnc_pkg::WORD_W-1:0]    i_wr_word,
    output logic [fnc_pkg::WORD_W-1:0]   o_rd_word,
    output logic                         o_rd_valid
);

    logic [fnc_pkg::WORD_W-1:0] r_cells [DEPTH];
    logic                       r_marks [DEPTH];

    // data array: never cleared, every use is gated by the valid mark
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en && i_req.wr_cell) begin
            r_cells[i_addr] <= i_wr_word;
        end
        if (i_req.rd_en) begin
            o_rd_word <= r_cells[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_marks[i_addr] <= i_req.wr_valid;
        end
        if (i_req.rd_en) begin
            o_rd_valid <= r_marks[i_addr];
        end
    end

endmodule

`default_nettype wire

### design/fnc_dist.sv
// Squared Euclidean distance pipeline: magnitude, square, pair sum, total.
// Carries a live flag and the cell position alongside; uses fnc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fnc_dist (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_live,
    input  wire fnc_pkg::t_cell_pos          i_pos,
    input  wire [fnc_pkg::WORD_W-1:0]        i_meas,
    input  wire [fnc_pkg::WORD_W-1:0]        i_word,
    output logic                             o_live,
    output fnc_pkg::t_cell_pos               o_pos,
    output logic [fnc_pkg::DIST_W-1:0]       o_dist
);

    localparam int N  = fnc_pkg::SENSOR_COUNT;
    localparam int SW = fnc_pkg::SENSOR_W;
    localparam int QW = fnc_pkg::SQ_W;
    localparam int NS = fnc_pkg::DIST_STAGES;

    logic [SW:0]               diff  [N];
    logic [SW-1:0]             n_mag [N];
    logic [SW-1:0]             r_mag [N];
    logic [QW-1:0]             r_sq  [N];
    logic [QW:0]               r_pair [2];
    logic [fnc_pkg::DIST_W-1:0] r_dist;
    logic                      r_live [NS];
    fnc_pkg::t_cell_pos        r_pos  [NS];

    always_comb begin
        for (int k = 0; k < N; k++) begin
            diff[k] = {i_meas[SW*k+SW-1], i_meas[SW*k +: SW]}
                    - {i_word[SW*k+SW-1], i_word[SW*k +: SW]};
            n_mag[k] = diff[k][SW] ? SW'(~diff[k] + 1'b1) : diff[k][SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N; k++) begin
            r_mag[k] <= n_mag[k];
            r_sq[k]  <= QW'(r_mag[k] * r_mag[k]);
        end
        r_pair[0] <= {1'b0, r_sq[0]} + {1'b0, r_sq[1]};
        r_pair[1] <= {1'b0, r_sq[2]} + {1'b0, r_sq[3]};
        r_dist    <= {1'b0, r_pair[0]} + {1'b0, r_pair[1]};
        r_pos[0]  <= i_pos;
        for (int s = 1; s < NS; s++) begin
            r_pos[s] <= r_pos[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) begin
                r_live[s] <= 1'b0;
            end
        end else begin
            r_live[0] <= i_live;
            for (int s = 1; s < NS; s++) begin
                r_live[s] <= r_live[s-1];
            end
        end
    end

    assign o_live = r_live[NS-1];
    assign o_pos  = r_pos[NS-1];
    assign o_dist = r_dist;

endmodule

`default_nettype wire

### design/fingerprint_nearest_cell.sv
// Write and read each end in a result strobe. Locate's run is set by one memory read
// per cell of the L*C in use, L and C being the lines and columns in use, and by
// the four-stage distance pipeline. One item at a time; start is taken again
// in the cycle of the strobe. Results cannot be stalled. Reset (synchronous, active low)
// sets both registers to 16 and runs a valid-clearing pass over all MAX_LINES*MAX_COLUMNS
// cells with busy high; configuration words are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

module fingerprint_nearest_cell #(
    parameter int MAX_LINES   = 16,
    parameter int MAX_COLUMNS = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire fnc_pkg::t_cmd               i_cmd,
    output logic                             o_busy,
    output logic                             o_done,
    output fnc_pkg::t_result                 o_result,
    input  wire                              i_cfg_valid,
    input  wire [fnc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [fnc_pkg::CFG_W-1:0]         i_cfg_data,
    output logic                             o_cfg_ready
);

    localparam int CELLS      = MAX_LINES * MAX_COLUMNS;
    localparam int AW         = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW         = fnc_pkg::CFG_W;
    localparam int DRAIN_LAST = fnc_pkg::DIST_STAGES + 1;
    localparam int DRAIN_W    = $clog2(DRAIN_LAST + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_SCAN,
        S_DRAIN
    } t_state;

    t_state                        r_state, n_state;
    fnc_pkg::t_cmd                 r_cmd, n_cmd;
    logic                          r_done, n_done;
    fnc_pkg::t_result              r_result, n_result;
    logic [CW-1:0]                 r_lines, r_columns;
    logic [AW-1:0]                 r_clr_addr, n_clr_addr;
    logic [CW-1:0]                 r_line, n_line;
    logic [CW-1:0]                 r_col, n_col;
    logic [AW-1:0]                 r_base, n_base;
    logic                          r_issue, n_issue;
    fnc_pkg::t_cell_pos            r_issue_pos, n_issue_pos;
    logic [DRAIN_W-1:0]            r_drain, n_drain;
    logic                          r_found, n_found;
    logic [fnc_pkg::DIST_W-1:0]    r_best, n_best;
    fnc_pkg::t_cell_pos            r_best_pos, n_best_pos;

    logic [CW-1:0]                 lines_bound, columns_bound;
    logic                          in_bounds;
    logic [AW-1:0]                 cmd_addr;
    logic [fnc_pkg::WORD_W-1:0]    cmd_word;

    fnc_pkg::t_mem_req             mem_req;
    logic [AW-1:0]                 mem_addr;
    logic [fnc_pkg::WORD_W-1:0]    rd_word;
    logic                          rd_valid;

    logic                          dist_live;
    fnc_pkg::t_cell_pos            dist_pos;
    logic [fnc_pkg::DIST_W-1:0]    cell_gap;

    fnc_store #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_store (
        .i_clk      (i_clk),
        .i_req      (mem_req),
        .i_addr     (mem_addr),
        .i_wr_word  (cmd_word),
        .o_rd_word  (rd_word),
        .o_rd_valid (rd_valid)
    );

    // read data and the issue tag line up in the cycle after the scan read
    fnc_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_live  (r_issue && rd_valid),
        .i_pos   (r_issue_pos),
        .i_meas  (cmd_word),
        .i_word  (rd_word),
        .o_live  (dist_live),
        .o_pos   (dist_pos),
        .o_dist  (cell_gap)
    );

    // saturate the registers to the grid size
    always_comb begin
        lines_bound   = (int'(r_lines) > MAX_LINES) ? CW'(MAX_LINES) : r_lines;
        columns_bound = (int'(r_columns) > MAX_COLUMNS) ? CW'(MAX_COLUMNS) : r_columns;
    end

    assign in_bounds = ({1'b0, r_cmd.line} < lines_bound)
                    && ({1'b0, r_cmd.column} < columns_bound);
    assign cmd_addr  = AW'(int'(r_cmd.line) * MAX_COLUMNS + int'(r_cmd.column));
    assign cmd_word  = {r_cmd.sensor_d, r_cmd.sensor_c, r_cmd.sensor_b, r_cmd.sensor_a};

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_done      = 1'b0;
        n_result    = r_result;
        n_clr_addr  = r_clr_addr;
        n_line      = r_line;
        n_col       = r_col;
        n_base      = r_base;
        n_issue     = 1'b0;
        n_issue_pos = r_issue_pos;
        n_drain     = r_drain;
        n_found     = r_found;
        n_best      = r_best;
        n_best_pos  = r_best_pos;
        mem_req     = '0;
        mem_addr    = cmd_addr;

        // keep the earlier cell on equal distance: strict less-than only
        if (dist_live && (!r_found || cell_gap < r_best)) begin
            n_found    = 1'b1;
            n_best     = cell_gap;
            n_best_pos = dist_pos;
        end

        unique case (r_state)
            S_CLEAR: begin
                mem_req.wr_en = 1'b1;
                mem_addr      = r_clr_addr;
                n_clr_addr    = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_cmd   = i_cmd;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_result = '0;
                n_state  = S_IDLE;
                if (r_cmd.operation == fnc_pkg::OP_WRITE
                        || r_cmd.operation == fnc_pkg::OP_READ) begin
                    if (!in_bounds) begin
                        n_result.status = fnc_pkg::ST_BOUNDS;
                        n_done          = 1'b1;
                    end else if (r_cmd.operation == fnc_pkg::OP_WRITE) begin
                        mem_req.wr_en    = 1'b1;
                        mem_req.wr_cell  = 1'b1;
                        mem_req.wr_valid = 1'b1;
                        n_done           = 1'b1;
                    end else begin
                        mem_req.rd_en = 1'b1;
                        n_state       = S_RDWAIT;
                    end
                end else if (r_cmd.operation == fnc_pkg::OP_LOCATE) begin
                    n_line  = '0;
                    n_col   = '0;
                    n_base  = '0;
                    n_found = 1'b0;
                    n_drain = '0;
                    // an empty area in use skips straight to the final decision
                    n_state = (lines_bound == '0 || columns_bound == '0) ? S_DRAIN : S_SCAN;
                end else begin
                    n_done = 1'b1;
                end
            end
            S_RDWAIT: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
                if (rd_valid) begin
                    n_result.value_a = rd_word[15:0];
                    n_result.value_b = rd_word[31:16];
                    n_result.value_c = rd_word[47:32];
                    n_result.value_d = rd_word[63:48];
                end else begin
                    n_result.status = fnc_pkg::ST_EMPTY;
                end
            end
            S_SCAN: begin
                // one cell per cycle in line-major order
                mem_req.rd_en      = 1'b1;
                mem_addr           = r_base + AW'(r_col);
                n_issue            = 1'b1;
                n_issue_pos.line   = r_line[3:0];
                n_issue_pos.column = r_col[3:0];
                if (r_col + 1'b1 == columns_bound) begin
                    n_col  = '0;
                    n_line = r_line + 1'b1;
                    n_base = r_base + AW'(MAX_COLUMNS);
                    if (r_line + 1'b1 == lines_bound) begin
                        n_drain = '0;
                        n_state = S_DRAIN;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            S_DRAIN: begin
                // wait out the memory read and the distance pipeline
                n_drain = r_drain + 1'b1;
                if (r_drain == DRAIN_W'(DRAIN_LAST)) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    if (r_found) begin
                        n_result.best_line   = r_best_pos.line;
                        n_result.best_column = r_best_pos.column;
                    end else begin
                        n_result.status = fnc_pkg::ST_EMPTY;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cmd       <= '0;
            r_done      <= 1'b0;
            r_result    <= '0;
            r_clr_addr  <= '0;
            r_line      <= '0;
            r_col       <= '0;
            r_base      <= '0;
            r_issue     <= 1'b0;
            r_issue_pos <= '0;
            r_drain     <= '0;
            r_found     <= 1'b0;
            r_best      <= '0;
            r_best_pos  <= '0;
        end else begin
            r_state     <= n_state;
            r_cmd       <= n_cmd;
            r_done      <= n_done;
            r_result    <= n_result;
            r_clr_addr  <= n_clr_addr;
            r_line      <= n_line;
            r_col       <= n_col;
            r_base      <= n_base;
            r_issue     <= n_issue;
            r_issue_pos <= n_issue_pos;
            r_drain     <= n_drain;
            r_found     <= n_found;
            r_best      <= n_best;
            r_best_pos  <= n_best_pos;
        end
    end

    // the user must send configuration words only while idle; the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lines   <= fnc_pkg::CFG_RESET;
            r_columns <= fnc_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fnc_pkg::CFG_LINES:   r_lines   <= i_cfg_data;
                fnc_pkg::CFG_COLUMNS: r_columns <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_result    = r_result;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

### design/fnc_checker.sv
// Port-level checks for fingerprint_nearest_cell, bound to the top level.
// Depends on fnc_pkg and the top-level ports.
`timescale 1ns / 1ps
`default_nettype none

module fnc_checker (
    input wire                      i_clk,
    input wire                      i_rst_n,
    input wire                      i_start,
    input wire                      i_busy,
    input wire                      i_done,
    input wire fnc_pkg::t_result    i_result
);

    // an accepted word holds the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !i_busy) |=> i_busy)
        else $error("accepted word did not raise busy");

    // a result only ever closes a busy period
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_done |-> $past(i_busy))
        else $error("result strobe without a preceding busy cycle");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_done |=> !i_done)
        else $error("result strobe held for more than one cycle");

    // a failed operation reports nothing but its status
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_done && i_result.status != fnc_pkg::ST_OK) |->
            (i_result.best_line == 4'd0 && i_result.best_column == 4'd0
             && i_result.value_a == 16'sd0 && i_result.value_b == 16'sd0
             && i_result.value_c == 16'sd0 && i_result.value_d == 16'sd0))
        else $error("failed operation carried non-zero fields");

endmodule

bind fingerprint_nearest_cell fnc_checker u_fnc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .i_busy   (o_busy),
    .i_done   (o_done),
    .i_result (o_result)
);

`default_nettype wire
